[rtl/core/fet_pkg.sv]
// Shared constants for the fractal escape-time engine.
package fet_pkg;

    // Width of the configuration register index.
    localparam int CFG_INDEX_BITS = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_JULIA_MODE       = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_JULIA_CONST_REAL = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_JULIA_CONST_IMAG = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_ITERATIONS   = 2'd3;

    // The escape radius squared is 4, which is 2 to this power.
    localparam int ESCAPE_LOG2 = 2;

    // Reset value of the iteration limit.
    localparam int MAX_ITER_RESET = 256;

endpackage

[rtl/core/fractal_escape_time.sv]
// Escape-time engine for Mandelbrot and Julia points with one shared multiplier.
//
//  Channel   Direction  Handshake                   Payload
//  input     in         i_in_valid / o_in_stall     i_point_real, i_point_imag
//  result    out        o_out_valid / i_out_stall   o_escape_count
//  config    in         i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// A point runs at most max_iterations iterations. Each one steps through the
// states S_SQR, S_SQI, S_TEST and S_UPD: the single WORD_BITS x WORD_BITS
// multiplier does zr*zr, zi*zi and zr*zi in turn, and S_UPD updates z. Reset
// is synchronous and active low; it clears the sequencer and the result valid
// and returns the configuration registers to their reset values.
// The input side stalls while a point is in work. A finished result waits in
// the sequencer if the output register is still held by a stalled beat.
//
// Each point runs through the following sequence. The squares of the starting
// z are formed first; they are not tested for escape. Then every iteration
// forms zr*zi, updates z from the stored squares and the product, and forms
// the squares of the new z, which serve both the escape test and the next
// update. The countdown starts at max_iterations and drops by one for each
// iteration that does not escape.
module fractal_escape_time #(
    parameter int FRAC_BITS  = 26,
    parameter int WORD_BITS  = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Point input channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [WORD_BITS-1:0]         i_point_real,
    input  logic signed [WORD_BITS-1:0]         i_point_imag,
    // Result channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic        [COUNT_BITS-1:0]        o_escape_count,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [fet_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic        [WORD_BITS-1:0]         i_cfg_data
);

    // Width of a product, and of the extended sums built from products.
    localparam int PW = 2 * WORD_BITS;
    localparam int XW = PW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQR,
        S_SQI,
        S_TEST,
        S_UPD,
        S_DONE
    } t_state;

    // Configuration registers.
    logic                          r_julia_mode;
    logic signed [WORD_BITS-1:0]   r_julia_cr;
    logic signed [WORD_BITS-1:0]   r_julia_ci;
    logic        [COUNT_BITS-1:0]  r_max_iter;

    // Sequencer and datapath registers.
    t_state                        r_state,     n_state;
    logic signed [WORD_BITS-1:0]   r_zr,        n_zr;
    logic signed [WORD_BITS-1:0]   r_zi,        n_zi;
    logic signed [WORD_BITS-1:0]   r_cr,        n_cr;
    logic signed [WORD_BITS-1:0]   r_ci,        n_ci;
    logic signed [PW-1:0]          r_sqr,       n_sqr;
    logic signed [PW-1:0]          r_sqi,       n_sqi;
    logic signed [PW-1:0]          r_prod;
    logic        [COUNT_BITS-1:0]  r_count,     n_count;
    logic        [COUNT_BITS-1:0]  r_result,    n_result;
    logic                          r_first,     n_first;
    logic                          r_out_valid, n_out_valid;
    logic        [COUNT_BITS-1:0]  r_out_count, n_out_count;

    // Shared multiplier operands and product.
    logic signed [WORD_BITS-1:0]   mul_a;
    logic signed [WORD_BITS-1:0]   mul_b;
    logic signed [PW-1:0]          mul_p;

    // Update and escape-test terms.
    logic signed [XW-1:0]          re_diff;
    logic signed [XW-1:0]          re_sum;
    logic signed [XW-1:0]          im_sum;
    logic        [XW-1:0]          mag;
    logic                          escaped;
    logic signed [WORD_BITS-1:0]   re_sat;
    logic signed [WORD_BITS-1:0]   im_sat;
    logic                          in_beat;

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_escape_count = r_out_count;
    assign in_beat        = i_in_valid && (r_state == S_IDLE);

    // The multiplier squares zr, then zi, and forms zr*zi in every other state.
    always_comb begin
        unique case (r_state)
            S_SQR: begin
                mul_a = r_zr;
                mul_b = r_zr;
            end
            S_SQI: begin
                mul_a = r_zi;
                mul_b = r_zi;
            end
            default: begin
                mul_a = r_zr;
                mul_b = r_zi;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // New z: the real part is floor((zr^2 - zi^2) / 2^F) + cr and the imaginary
    // part is floor(zr*zi / 2^(F-1)) + ci. Both saturate to the word range.
    always_comb begin
        re_diff = $signed({r_sqr[PW-1], r_sqr}) - $signed({r_sqi[PW-1], r_sqi});
        re_sum  = (re_diff >>> FRAC_BITS) + XW'(r_cr);
        im_sum  = ($signed({r_prod[PW-1], r_prod}) >>> (FRAC_BITS - 1)) + XW'(r_ci);

        if ((&re_sum[XW-1:WORD_BITS-1]) || !(|re_sum[XW-1:WORD_BITS-1])) begin
            re_sat = re_sum[WORD_BITS-1:0];
        end else begin
            re_sat = re_sum[XW-1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                  : {1'b0, {(WORD_BITS-1){1'b1}}};
        end
        if ((&im_sum[XW-1:WORD_BITS-1]) || !(|im_sum[XW-1:WORD_BITS-1])) begin
            im_sat = im_sum[WORD_BITS-1:0];
        end else begin
            im_sat = im_sum[XW-1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                  : {1'b0, {(WORD_BITS-1){1'b1}}};
        end
    end

    // Escape test in the test state: zr^2 sits in r_sqr and zi^2 in r_prod.
    // Both are non-negative, and |z|^2 >= 4 means a bit at or above
    // 2^(2F+2) is set.
    always_comb begin
        mag     = {1'b0, r_sqr} + {1'b0, r_prod};
        escaped = |(mag >> (2 * FRAC_BITS + fet_pkg::ESCAPE_LOG2));
    end

    // Sequencer next-state logic.
    always_comb begin
        n_state     = r_state;
        n_zr        = r_zr;
        n_zi        = r_zi;
        n_cr        = r_cr;
        n_ci        = r_ci;
        n_sqr       = r_sqr;
        n_sqi       = r_sqi;
        n_count     = r_count;
        n_result    = r_result;
        n_first     = r_first;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_count = r_out_count;

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    if (r_julia_mode) begin
                        n_zr = i_point_real;
                        n_zi = i_point_imag;
                        n_cr = r_julia_cr;
                        n_ci = r_julia_ci;
                    end else begin
                        n_zr = '0;
                        n_zi = '0;
                        n_cr = i_point_real;
                        n_ci = i_point_imag;
                    end
                    n_count = r_max_iter;
                    n_first = 1'b1;
                    if (r_max_iter == '0) begin
                        // A zero iteration limit runs nothing and answers zero.
                        n_result = '0;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_SQR;
                    end
                end
            end
            S_SQR: begin
                n_state = S_SQI;
            end
            S_SQI: begin
                n_sqr   = r_prod;
                n_state = S_TEST;
            end
            S_TEST: begin
                n_sqi   = r_prod;
                n_first = 1'b0;
                if (!r_first && escaped) begin
                    n_result = r_count;
                    n_state  = S_DONE;
                end else if (!r_first && (r_count == COUNT_BITS'(1))) begin
                    n_result = '0;
                    n_state  = S_DONE;
                end else begin
                    if (!r_first) begin
                        n_count = r_count - COUNT_BITS'(1);
                    end
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_zr    = re_sat;
                n_zi    = im_sat;
                n_state = S_SQR;
            end
            S_DONE: begin
                if (!(r_out_valid && i_out_stall)) begin
                    n_out_valid = 1'b1;
                    n_out_count = r_result;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer state, datapath and result register.
    always_ff @(posedge i_clk) begin
        r_prod      <= mul_p;
        r_zr        <= n_zr;
        r_zi        <= n_zi;
        r_cr        <= n_cr;
        r_ci        <= n_ci;
        r_sqr       <= n_sqr;
        r_sqi       <= n_sqi;
        r_count     <= n_count;
        r_result    <= n_result;
        r_first     <= n_first;
        r_out_count <= n_out_count;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Config registers; user writes only while the engine is idle, unchecked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_julia_mode <= 1'b0;
            r_julia_cr   <= '0;
            r_julia_ci   <= '0;
            r_max_iter   <= COUNT_BITS'(fet_pkg::MAX_ITER_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fet_pkg::CFG_JULIA_MODE:       r_julia_mode <= i_cfg_data[0];
                fet_pkg::CFG_JULIA_CONST_REAL: r_julia_cr   <= i_cfg_data;
                fet_pkg::CFG_JULIA_CONST_IMAG: r_julia_ci   <= i_cfg_data;
                fet_pkg::CFG_MAX_ITERATIONS:   r_max_iter   <= i_cfg_data[COUNT_BITS-1:0];
            endcase
        end
    end

endmodule

[rtl/core/fet_checker.sv]
// Port-level checks for the fractal escape-time engine, bound to its top level.
module fet_checker #(
    parameter int WORD_BITS  = 32,
    parameter int COUNT_BITS = 16
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic signed [WORD_BITS-1:0]         i_point_real,
    input logic signed [WORD_BITS-1:0]         i_point_imag,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic        [COUNT_BITS-1:0]        o_escape_count
);

    // Reset leaves no result beat pending.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result beat keeps its count.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_escape_count))
        else $error("stalled result changed");

    // A stalled point beat stays offered and keeps its coordinates.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=>
            i_in_valid && $stable(i_point_real) && $stable(i_point_imag))
        else $error("stalled point changed");

    // An accepted point keeps the engine busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("engine took no time for a point");

    // A new result appears only out of a busy engine.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a point in work");

endmodule

bind fractal_escape_time fet_checker #(
    .WORD_BITS  (WORD_BITS),
    .COUNT_BITS (COUNT_BITS)
) u_fet_checker (.*);

[sim/escape_checker.sv]
// Checker for the escape-time engine: tracks configuration, predicts counts, compares results.
`timescale 1ns / 1ps

module escape_checker #(
    parameter int FRAC_BITS  = 26,
    parameter int WORD_BITS  = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic signed [WORD_BITS-1:0]         i_point_real,
    input  logic signed [WORD_BITS-1:0]         i_point_imag,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic        [COUNT_BITS-1:0]        i_escape_count,
    input  logic                                i_cfg_we,
    input  logic [fet_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic        [WORD_BITS-1:0]         i_cfg_data,
    output int                                  o_pending,
    output int                                  o_fail_count
);

    typedef logic signed [WORD_BITS-1:0]   t_word;
    typedef logic        [COUNT_BITS-1:0]  t_count;
    typedef logic signed [4*WORD_BITS-1:0] t_acc;

    localparam t_acc WORD_HI      = (t_acc'(1) <<< (WORD_BITS - 1)) - t_acc'(1);
    localparam t_acc WORD_LO      = -(t_acc'(1) <<< (WORD_BITS - 1));
    localparam t_acc ESCAPE_LIMIT =
        t_acc'(1) <<< (2 * FRAC_BITS + fet_pkg::ESCAPE_LOG2);

    logic   julia_sel;
    t_word  julia_re;
    t_word  julia_im;
    t_count iter_limit;
    t_count expected_counts[$];
    int     fail_total;

    function automatic t_word clamp_word(input t_acc v);
        if (v > WORD_HI) return t_word'(WORD_HI);
        if (v < WORD_LO) return t_word'(WORD_LO);
        return t_word'(v);
    endfunction

    // Runs the iteration on exact wide products and returns the countdown at escape.
    function automatic t_count escape_countdown(input t_word pr, input t_word pi);
        t_word  zr;
        t_word  zi;
        t_word  cr;
        t_word  ci;
        t_acc   re;
        t_acc   im;
        t_acc   mag;
        t_count n;
        if (julia_sel) begin
            cr = julia_re;
            ci = julia_im;
            zr = pr;
            zi = pi;
        end else begin
            cr = pr;
            ci = pi;
            zr = '0;
            zi = '0;
        end
        for (n = iter_limit; n != 0; n--) begin
            re  = ((t_acc'(zr) * t_acc'(zr) - t_acc'(zi) * t_acc'(zi)) >>> FRAC_BITS)
                  + t_acc'(cr);
            im  = ((t_acc'(zr) * t_acc'(zi)) >>> (FRAC_BITS - 1)) + t_acc'(ci);
            zr  = clamp_word(re);
            zi  = clamp_word(im);
            mag = t_acc'(zr) * t_acc'(zr) + t_acc'(zi) * t_acc'(zi);
            if (mag >= ESCAPE_LIMIT) return n;
        end
        return '0;
    endfunction

    always @(posedge i_clk) begin
        t_count want;
        if (!i_rst_n) begin
            julia_sel  = 1'b0;
            julia_re   = '0;
            julia_im   = '0;
            iter_limit = t_count'(fet_pkg::MAX_ITER_RESET);
            fail_total = 0;
            expected_counts.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fet_pkg::CFG_JULIA_MODE:       julia_sel  = i_cfg_data[0];
                    fet_pkg::CFG_JULIA_CONST_REAL: julia_re   = i_cfg_data;
                    fet_pkg::CFG_JULIA_CONST_IMAG: julia_im   = i_cfg_data;
                    fet_pkg::CFG_MAX_ITERATIONS:   iter_limit = i_cfg_data[COUNT_BITS-1:0];
                    default: ;
                endcase
            end
            // Results are retired before new points are queued, so a stray result beat
            // cannot consume an expectation that was only created on the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (expected_counts.size() == 0) begin
                    $error("escape_count: unexpected result beat, actual %0d", i_escape_count);
                    fail_total++;
                end else begin
                    want = expected_counts.pop_front();
                    if (i_escape_count !== want) begin
                        $error("escape_count mismatch: expected %0d, actual %0d",
                               want, i_escape_count);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_counts.push_back(escape_countdown(i_point_real, i_point_imag));
        end
        o_pending    <= expected_counts.size();
        o_fail_count <= fail_total;
    end

endmodule

[sim/tb_top.sv]
// Top-level testbench for the escape-time engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int FRAC_BITS  = 26;
    localparam int WORD_BITS  = 32;
    localparam int COUNT_BITS = 16;

    typedef logic signed [WORD_BITS-1:0]               t_word;
    typedef logic        [fet_pkg::CFG_INDEX_BITS-1:0] t_reg_index;

    // A point can run 65535 iterations before its result appears, so the watchdog
    // must not fire while a single point is still in work.
    localparam int WATCHDOG_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PRESSURE_HOLD  = 400;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_POINTS   = 160;

    // Handy values in the Q6.26 format of the point and constant words.
    localparam t_word FX_ONE     = 32'sd67108864;
    localparam t_word FX_TWO     = 32'sd134217728;
    localparam t_word FX_HALF    = 32'sd33554432;
    localparam t_word FX_QUARTER = 32'sd16777216;
    localparam t_word WORD_MAX   = 32'sh7fff_ffff;
    localparam t_word WORD_MIN   = 32'sh8000_0000;
    // Most random coordinates fall inside +/-2.5, where the interesting behavior is.
    localparam int    PLANE_SPAN = 167772160;
    // The classic dendrite-like Julia constant, -0.8 + 0.156i.
    localparam t_word DEMO_C_RE  = -32'sd53687091;
    localparam t_word DEMO_C_IM  = 32'sd10468982;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_in_valid   = 1'b0;
    logic                   o_in_stall;
    t_word                  i_point_real = '0;
    t_word                  i_point_imag = '0;
    logic                   o_out_valid;
    logic                   i_out_stall  = 1'b0;
    logic [COUNT_BITS-1:0]  o_escape_count;
    logic                   i_cfg_we     = 1'b0;
    t_reg_index             i_cfg_index  = fet_pkg::CFG_JULIA_MODE;
    logic [WORD_BITS-1:0]   i_cfg_data   = '0;

    int pending_results;
    int fail_count;
    int idle_cycles     = 0;
    int hold_off_serial = 0;

    always #2 i_clk = ~i_clk;

    fractal_escape_time #(
        .FRAC_BITS  (FRAC_BITS),
        .WORD_BITS  (WORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_point_real   (i_point_real),
        .i_point_imag   (i_point_imag),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_escape_count (o_escape_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    escape_checker #(
        .FRAC_BITS  (FRAC_BITS),
        .WORD_BITS  (WORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_point_real   (i_point_real),
        .i_point_imag   (i_point_imag),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_escape_count (o_escape_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_pending      (pending_results),
        .o_fail_count   (fail_count)
    );

    // The watchdog only looks for progress: any accepted beat on either channel
    // restarts the count. A hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result sink. It works in segments: some with no back-pressure at all, some with
    // light or heavy random stalling, and some that stall solidly for a while. When the
    // stimulus asks for a hold-off, it keeps stall high for a long counted stretch so
    // that the engine fills up and has to push back on its input.
    initial begin
        int hold_seen;
        int seg_len;
        int seg_kind;
        hold_seen = 0;
        forever begin
            if (hold_off_serial != hold_seen) begin
                hold_seen = hold_off_serial;
                repeat (PRESSURE_HOLD) begin
                    @(posedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end else begin
                seg_kind = $urandom_range(0, 9);
                seg_len  = $urandom_range(8, 64);
                repeat (seg_len) begin
                    @(posedge i_clk);
                    case (seg_kind)
                        0, 1, 2:       i_out_stall <= 1'b0;
                        3, 4, 5, 6, 7: i_out_stall <= ($urandom_range(0, 3) == 0);
                        8:             i_out_stall <= 1'($urandom_range(0, 1));
                        default:       i_out_stall <= 1'b1;
                    endcase
                end
            end
        end
    end

    // Sender gaps: mostly none or short, now and then a long pause.
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(30, 150);
    endfunction

    // One coordinate: mostly inside the region around the sets, some fully random
    // words so that every bit toggles, and some hand-picked edge values.
    function automatic t_word random_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return t_word'(int'($urandom_range(0, 2 * PLANE_SPAN)) - PLANE_SPAN);
        if (r < 90) return t_word'($urandom());
        case ($urandom_range(0, 8))
            0: return '0;
            1: return WORD_MAX;
            2: return WORD_MIN;
            3: return FX_TWO;
            4: return -FX_TWO;
            5: return FX_ONE;
            6: return -FX_ONE;
            7: return 32'sd1;
            default: return -32'sd1;
        endcase
    endfunction

    // Offers one point and returns on the edge where it is taken. Valid stays high
    // from one beat to the next unless a gap is chosen.
    task automatic send_point(input t_word re, input t_word im, input bit gapless);
        int gap;
        gap = gapless ? 0 : sender_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_point_real <= re;
        i_point_imag <= im;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Register writes drop the enable again before returning, so the enable never toggles
    // twice within one time step.
    task automatic write_reg(input t_reg_index idx, input logic [WORD_BITS-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Narrow registers get random upper bits, which the engine has to ignore.
    task automatic set_mode(input bit julia);
        write_reg(fet_pkg::CFG_JULIA_MODE, {(WORD_BITS - 1)'($urandom()), julia});
    endtask

    task automatic set_limit(input int unsigned limit);
        write_reg(fet_pkg::CFG_MAX_ITERATIONS,
                  {16'($urandom()), COUNT_BITS'(limit)});
    endtask

    // Stops offering points and waits until every predicted result has been taken.
    // The first edge lets the checker's pending count catch up with the last beat.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        bit gapless;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed points under the reset configuration: Mandelbrot, limit 256.
        // The origin and the cusp at 0.25 never escape; -2 lands exactly on |z|^2 = 4
        // in the first iteration; the word extremes escape in the first iteration too.
        send_point('0, '0, 1'b0);
        send_point(-FX_TWO, '0, 1'b0);
        send_point(FX_QUARTER, '0, 1'b0);
        send_point(-FX_ONE, '0, 1'b0);
        send_point('0, FX_ONE, 1'b0);
        send_point(WORD_MAX, WORD_MAX, 1'b0);
        send_point(WORD_MIN, WORD_MIN, 1'b0);
        send_point(WORD_MIN, WORD_MAX, 1'b0);
        send_point(32'sd1, -32'sd1, 1'b0);
        wait_idle();

        // Julia mode with a well-known constant and a short limit.
        set_mode(1'b1);
        write_reg(fet_pkg::CFG_JULIA_CONST_REAL, DEMO_C_RE);
        write_reg(fet_pkg::CFG_JULIA_CONST_IMAG, DEMO_C_IM);
        set_limit(64);
        send_point('0, '0, 1'b0);
        send_point(FX_HALF, FX_HALF, 1'b0);
        send_point(FX_TWO, '0, 1'b0);
        send_point(WORD_MAX, WORD_MIN, 1'b0);
        wait_idle();

        // Julia constants at the word extremes.
        write_reg(fet_pkg::CFG_JULIA_CONST_REAL, WORD_MIN);
        write_reg(fet_pkg::CFG_JULIA_CONST_IMAG, WORD_MAX);
        send_point('0, '0, 1'b0);
        send_point(WORD_MIN, '0, 1'b0);
        wait_idle();

        // A zero limit runs no iteration, so even a point far outside answers 0.
        set_mode(1'b0);
        set_limit(0);
        send_point(-FX_TWO, '0, 1'b0);
        send_point(WORD_MAX, '0, 1'b0);
        wait_idle();

        // A single iteration: escape answers 1, a bounded point answers 0.
        set_limit(1);
        send_point(-FX_TWO, '0, 1'b0);
        send_point('0, '0, 1'b0);
        wait_idle();

        // The full countdown width: a quick escape answers 65535, and the origin runs
        // the whole limit without escaping, the slowest point this block can get.
        set_limit(65535);
        send_point(WORD_MAX, '0, 1'b0);
        send_point('0, '0, 1'b0);
        wait_idle();

        // Random phases, each with its own configuration. Limits stay small in most
        // phases to keep the run short; a few phases use the default of 256, a few
        // use 1 and rarely 0. The second phase runs against a long receiver hold-off
        // with the sender offering points back to back.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            set_mode(1'($urandom_range(0, 1)));
            write_reg(fet_pkg::CFG_JULIA_CONST_REAL, random_coord());
            write_reg(fet_pkg::CFG_JULIA_CONST_IMAG, random_coord());
            case ($urandom_range(0, 19))
                0:       set_limit(0);
                1, 2:    set_limit(1);
                3, 4, 5: set_limit(fet_pkg::MAX_ITER_RESET);
                default: set_limit($urandom_range(2, 64));
            endcase
            gapless = (phase == 1) || ($urandom_range(0, 3) == 0);
            if (phase == 1) hold_off_serial++;
            repeat (PHASE_POINTS) send_point(random_coord(), random_coord(), gapless);
        end
        wait_idle();

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/fet_pkg.sv
rtl/core/fractal_escape_time.sv
rtl/core/fet_checker.sv
sim/escape_checker.sv
sim/tb_top.sv
